// ----- src/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define CHK_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/lrtp_pkg.sv -----
`timescale 1ns / 1ps

package lrtp_pkg;

  localparam int CMD_W   = 2;
  localparam int STATE_W = 6;
  localparam int SYM_W   = 8;
  localparam int LEN_W   = 6;
  localparam int LEVEL_W = 7;
  localparam int ENTRY_W = 16;
  localparam int IN_W    = 32;
  localparam int OUT_W   = 16;
  localparam int CFG_W   = 8;

  typedef enum logic [1:0] {
    CMD_WRITE    = 2'd0,
    CMD_NEW_WORD = 2'd1,
    CMD_FEED     = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    KIND_EMPTY  = 2'd0,
    KIND_SHIFT  = 2'd1,
    KIND_REDUCE = 2'd2,
    KIND_ACCEPT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    VERD_PENDING  = 2'd0,
    VERD_ACCEPT   = 2'd1,
    VERD_REJECT   = 2'd2,
    VERD_OVERFLOW = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_LOOK_DEC,
    ST_STACK,
    ST_GOTO,
    ST_GOTO_DEC,
    ST_FINISH
  } ctl_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic     clr;
    logic     take;
    logic     rd_goto;
    logic     red_count;
    logic     shift_push;
    logic     goto_push;
    logic     set_verdict;
    verdict_t verdict;
    logic     start_end;
    logic     out_load;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    cmd_e_t in_cmd;
    logic   verdict_zero;
    logic   last_item;
    logic   end_phase;
    kind_t  act_kind;
    logic   act_ok;
    logic   len_too_big;
    logic   limit_hit;
    logic   shift_full;
    logic   goto_full;
    logic   goto_ok;
    logic   clear_done;
  } ctl_stat_t;

endpackage

// ----- src/lr_table_driven_parse_engine.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake                     Payload
// in        input      in_tvalid / in_tready         in_tdata (32 bits), in_tuser, in_tlast
// out       output     out_tvalid / out_tready       out_tdata (16 bits)
// cfg       input      cfg_valid / cfg_ready         cfg_data (8 bits), end marker code
//
// After reset the action table is swept to empty entries, one entry per cycle, over all
// 2**clog2(rows) times 2**clog2(NUM_SYMBOLS) entries, rows being NUM_STATES capped at 64:
// 16384 by default. in_tready stays low during that sweep; configuration writes are
// taken throughout. A table write, new word, unused command or symbol for a decided word
// goes straight from acceptance to the result. A symbol that shifts directly passes the
// action lookup once; each reduction adds an action read, a stack read and a goto read
// through the single table read port, and a last symbol runs the end marker through the
// same loop, with its own action lookup plus its reductions.
// A finished result waits in the output register; the block stalls before loading the
// next result until the previous one has been taken.
module lr_table_driven_parse_engine import lrtp_pkg::*; #(
  parameter int NUM_STATES  = 64,
  parameter int NUM_SYMBOLS = 256,
  parameter int STACK_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  // in_tdata fields from bit 0 up: state_index[5:0], symbol[13:6], action_kind[15:14],
  // action_value[21:16], reduce_lhs[29:22], bits 31:30 zero. in_tlast is is_last.
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  // in_tuser fields from bit 0 up: cmd[1:0].
  input  logic [CMD_W-1:0] in_tuser,
  input  logic             in_tlast,
  // out_tdata fields from bit 0 up: verdict[1:0], current_state[7:2],
  // stack_level[14:8], bit 15 zero.
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  // End-of-input marker register.
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  ctl_cmd_t  ctl;
  ctl_stat_t stat;

  // End marker register is always writable, so the caller must change it only while idle.
  assign cfg_ready = 1'b1;

  // The controller sequences each item: accept, table lookup, reduce loop, result.
  lrtp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .ctl        (ctl)
  );

  // The datapath holds the action table, the state stack, the stack pointer,
  // the word verdict and the result register.
  lrtp_datapath #(
    .NUM_STATES  (NUM_STATES),
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .stat      (stat),
    .out_tdata (out_tdata)
  );

endmodule

// ----- src/lrtp_ctrl.sv -----
`timescale 1ns / 1ps

module lrtp_ctrl import lrtp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  ctl_stat_t stat,
  output ctl_cmd_t  ctl
);

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      out_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.out_load) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_tready  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ctl.clr = 1'b1;
        if (stat.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.take = 1'b1;
          if (stat.in_cmd == CMD_FEED && stat.verdict_zero) begin
            state_next = ST_LOOK;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_LOOK: begin
        state_next = ST_LOOK_DEC;
      end
      ST_LOOK_DEC: begin
        state_next = ST_FINISH;
        if (!stat.act_ok) begin
          ctl.set_verdict = 1'b1;
          ctl.verdict     = VERD_REJECT;
        end else begin
          unique case (stat.act_kind)
            KIND_EMPTY: begin
              ctl.set_verdict = 1'b1;
              ctl.verdict     = VERD_REJECT;
            end
            KIND_ACCEPT: begin
              ctl.set_verdict = 1'b1;
              ctl.verdict     = VERD_ACCEPT;
            end
            KIND_SHIFT: begin
              ctl.shift_push = 1'b1;
              if (!stat.shift_full) begin
                if (stat.end_phase) begin
                  // Shifting the end marker itself means the word is not in the language.
                  ctl.set_verdict = 1'b1;
                  ctl.verdict     = VERD_REJECT;
                end else if (stat.last_item) begin
                  ctl.start_end = 1'b1;
                  state_next    = ST_LOOK;
                end
              end
            end
            KIND_REDUCE: begin
              if (stat.limit_hit || stat.len_too_big) begin
                ctl.set_verdict = 1'b1;
                ctl.verdict     = VERD_REJECT;
              end else begin
                ctl.red_count = 1'b1;
                state_next    = ST_STACK;
              end
            end
            default: begin
              ctl.set_verdict = 1'b1;
              ctl.verdict     = VERD_REJECT;
            end
          endcase
        end
      end
      ST_STACK: begin
        state_next = ST_GOTO;
      end
      ST_GOTO: begin
        ctl.rd_goto = 1'b1;
        state_next  = ST_GOTO_DEC;
      end
      ST_GOTO_DEC: begin
        if (!stat.goto_ok) begin
          ctl.set_verdict = 1'b1;
          ctl.verdict     = VERD_REJECT;
          state_next      = ST_FINISH;
        end else begin
          ctl.goto_push = 1'b1;
          state_next    = stat.goto_full ? ST_FINISH : ST_LOOK;
        end
      end
      ST_FINISH: begin
        if (!out_tvalid || out_tready) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- src/lrtp_datapath.sv -----
`timescale 1ns / 1ps

module lrtp_datapath import lrtp_pkg::*; #(
  parameter int NUM_STATES  = 64,
  parameter int NUM_SYMBOLS = 256,
  parameter int STACK_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic [CMD_W-1:0] in_tuser,
  input  logic             in_tlast,
  input  logic             cfg_valid,
  input  logic [CFG_W-1:0] cfg_data,
  input  ctl_cmd_t         ctl,
  output ctl_stat_t        stat,
  output logic [OUT_W-1:0] out_tdata
);

  localparam int ROWS  = (NUM_STATES < (1 << STATE_W)) ? NUM_STATES : (1 << STATE_W);
  localparam int RW    = $clog2(ROWS);
  localparam int YW    = $clog2(NUM_SYMBOLS);
  localparam int AW    = RW + YW;
  localparam int SW    = $clog2(STACK_DEPTH);
  localparam int PW    = $clog2(STACK_DEPTH + 1);
  localparam int XW    = ((PW > STATE_W) ? PW : STATE_W) + 1;
  localparam int LIMIT = NUM_STATES * STACK_DEPTH;
  localparam int CW    = $clog2(LIMIT + 1);

  // Input item fields.
  cmd_e_t             in_cmd;
  logic [STATE_W-1:0] in_row;
  logic [SYM_W-1:0]   in_sym;
  logic [1:0]         in_kind;
  logic [LEN_W-1:0]   in_val;
  logic [SYM_W-1:0]   in_lhs;

  assign in_cmd  = cmd_e_t'(in_tuser);
  assign in_row  = in_tdata[5:0];
  assign in_sym  = in_tdata[13:6];
  assign in_kind = in_tdata[15:14];
  assign in_val  = in_tdata[21:16];
  assign in_lhs  = in_tdata[29:22];

  // Parser state.
  logic [SYM_W-1:0]   end_symbol;
  logic [SYM_W-1:0]   cur_sym;
  logic               last_item;
  logic               end_phase;
  logic [PW-1:0]      sp;
  logic [STATE_W-1:0] top;
  verdict_t           verdict;
  logic [CW-1:0]      red_cnt;
  logic [AW-1:0]      clr_addr;
  logic [LEN_W-1:0]   red_len;
  logic [SYM_W-1:0]   red_lhs;
  logic [STATE_W-1:0] uncov;
  logic               tbl_ok;
  logic [OUT_W-1:0]   out_q;

  // Action table.
  logic [ENTRY_W-1:0] tbl_mem [0:(1 << AW)-1];
  logic [ENTRY_W-1:0] tbl_rdata;
  logic               tbl_we;
  logic [AW-1:0]      tbl_waddr;
  logic [ENTRY_W-1:0] tbl_wdata;
  logic [AW-1:0]      tbl_raddr;
  logic               tbl_rd_ok;
  logic               in_ok;

  // State stack.
  logic [STATE_W-1:0] stk_mem [0:STACK_DEPTH-1];
  logic [STATE_W-1:0] stk_rdata;
  logic               stk_we;
  logic [SW-1:0]      stk_waddr;
  logic [STATE_W-1:0] stk_wdata;
  logic [XW-1:0]      uncov_x;
  logic [XW-1:0]      red_x;
  logic [PW-1:0]      sp_red;
  logic [LEN_W-1:0]   act_len;
  logic [STATE_W-1:0] act_val;
  logic [STATE_W-1:0] goto_val;
  logic               shift_full;
  logic               goto_full;
  logic [LEVEL_W+PW-1:0] level_x;

  assign act_len  = tbl_rdata[7:2];
  assign act_val  = tbl_rdata[7:2];
  assign goto_val = tbl_rdata[7:2];

  assign in_ok = (32'(in_row) < NUM_STATES) && (32'(in_sym) < NUM_SYMBOLS);

  always_comb begin
    tbl_we    = ctl.clr || (ctl.take && in_cmd == CMD_WRITE && in_ok);
    tbl_waddr = ctl.clr ? clr_addr : {in_row[RW-1:0], in_sym[YW-1:0]};
    tbl_wdata = ctl.clr ? '0 : {in_lhs, in_val, in_kind};
    if (ctl.rd_goto) begin
      tbl_raddr = {stk_rdata[RW-1:0], red_lhs[YW-1:0]};
      tbl_rd_ok = (32'(stk_rdata) < NUM_STATES) && (32'(red_lhs) < NUM_SYMBOLS);
    end else begin
      tbl_raddr = {top[RW-1:0], cur_sym[YW-1:0]};
      tbl_rd_ok = (32'(top) < NUM_STATES) && (32'(cur_sym) < NUM_SYMBOLS);
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_rdata <= tbl_mem[tbl_raddr];
    tbl_ok    <= tbl_rd_ok;
  end

  // Stack addressing: the reduce reads the state uncovered below the popped rule.
  assign uncov_x    = XW'(sp) - XW'(1) - XW'(red_len);
  assign red_x      = XW'(sp) - XW'(red_len);
  assign sp_red     = red_x[PW-1:0];
  assign shift_full = 32'(sp) >= STACK_DEPTH;
  assign goto_full  = 32'(sp_red) >= STACK_DEPTH;

  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = '0;
    stk_wdata = '0;
    if (ctl.clr || (ctl.take && in_cmd == CMD_NEW_WORD)) begin
      stk_we = 1'b1;
    end else if (ctl.shift_push && !shift_full) begin
      stk_we    = 1'b1;
      stk_waddr = sp[SW-1:0];
      stk_wdata = act_val;
    end else if (ctl.goto_push && !goto_full) begin
      stk_we    = 1'b1;
      stk_waddr = sp_red[SW-1:0];
      stk_wdata = goto_val;
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata <= stk_mem[uncov_x[SW-1:0]];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      end_symbol <= '0;
      clr_addr   <= '0;
      sp         <= PW'(1);
      top        <= '0;
      verdict    <= VERD_PENDING;
    end else begin
      if (cfg_valid) begin
        end_symbol <= cfg_data;
      end
      if (ctl.clr) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (ctl.take && in_cmd == CMD_NEW_WORD) begin
        sp      <= PW'(1);
        top     <= '0;
        verdict <= VERD_PENDING;
      end
      if (ctl.shift_push) begin
        if (shift_full) begin
          verdict <= VERD_OVERFLOW;
        end else begin
          sp  <= sp + PW'(1);
          top <= act_val;
        end
      end
      if (ctl.goto_push) begin
        if (goto_full) begin
          sp      <= sp_red;
          top     <= uncov;
          verdict <= VERD_OVERFLOW;
        end else begin
          sp  <= sp_red + PW'(1);
          top <= goto_val;
        end
      end
      if (ctl.set_verdict) begin
        verdict <= ctl.verdict;
      end
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      cur_sym   <= in_sym;
      last_item <= in_tlast;
      end_phase <= 1'b0;
      red_cnt   <= '0;
    end else if (ctl.start_end) begin
      cur_sym   <= end_symbol;
      end_phase <= 1'b1;
      red_cnt   <= '0;
    end else if (ctl.red_count) begin
      red_cnt <= red_cnt + CW'(1);
    end
    if (ctl.red_count) begin
      red_len <= act_len;
      red_lhs <= tbl_rdata[15:8];
    end
    if (ctl.rd_goto) begin
      uncov <= stk_rdata;
    end
    if (ctl.out_load) begin
      out_q <= {1'b0, level_x[LEVEL_W-1:0], top, verdict};
    end
  end

  assign level_x   = {{LEVEL_W{1'b0}}, sp};
  assign out_tdata = out_q;

  always_comb begin
    stat.in_cmd       = in_cmd;
    stat.verdict_zero = (verdict == VERD_PENDING);
    stat.last_item    = last_item;
    stat.end_phase    = end_phase;
    stat.act_kind     = kind_t'(tbl_rdata[1:0]);
    stat.act_ok       = tbl_ok;
    stat.len_too_big  = XW'(act_len) >= XW'(sp);
    stat.limit_hit    = (red_cnt == CW'(LIMIT));
    stat.shift_full   = shift_full;
    stat.goto_full    = goto_full;
    stat.goto_ok      = tbl_ok && (kind_t'(tbl_rdata[1:0]) == KIND_SHIFT);
    stat.clear_done   = &clr_addr;
  end

endmodule

// ----- src/lrtp_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lrtp_checker import lrtp_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input logic             clk,
  input logic             rst,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // A stalled result keeps its value.
  `CHK_ASSERT(a_out_hold, clk, rst, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

  // Only one item is in the block at a time.
  `CHK_ASSERT_NR(a_one_item, clk, in_tvalid && in_tready |=> !in_tready, "item accepted while busy")

  // An overflow verdict is only reported with the stack full.
  `CHK_ASSERT(a_ovf_full, clk, rst, out_tvalid && out_tdata[1:0] == VERD_OVERFLOW |-> out_tdata[14:8] == 7'(STACK_DEPTH), "overflow with stack not full")

  // A result leaves only through a handshake.
  `CHK_ASSERT(a_out_drop, clk, rst, $fell(out_tvalid) |-> $past(out_tready), "result dropped")

endmodule

bind lr_table_driven_parse_engine lrtp_checker #(.STACK_DEPTH(STACK_DEPTH)) u_lrtp_checker (.*);
